/* src/gbdt_pkg.sv */
package gbdt_pkg;

    localparam int VTX_W = 3;
    localparam int LBL_W = 8;
    localparam int CNT_W = 4;

    localparam logic [1:0] CMD_EDGE = 2'd0;
    localparam logic [1:0] CMD_BFS  = 2'd1;
    localparam logic [1:0] CMD_DFS  = 2'd2;
    localparam logic [1:0] CMD_RSV  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_LINK,
        S_LINKCHK,
        S_WR1,
        S_WR2,
        S_NF,
        S_BPOP,
        S_BNB,
        S_BCHK,
        S_DTOP,
        S_DCHK,
        S_FLUSH
    } state_t;

    // Request from the sequencer to the adjacency store.
    typedef struct packed {
        logic             wr_en;
        logic [VTX_W-1:0] wr_vtx;
        logic [VTX_W-1:0] wr_nbr;
        logic             rd_en;
        logic [VTX_W-1:0] rd_vtx;
        logic [VTX_W-1:0] rd_pos;
    } adj_req_t;

endpackage

/* src/gbdt_adj.sv */
module gbdt_adj #(
    parameter int NUM_VERTICES = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gbdt_pkg::adj_req_t     req,
    output logic [gbdt_pkg::VTX_W-1:0] rd_data,
    output logic [gbdt_pkg::VTX_W-1:0] degree [NUM_VERTICES]
);
    import gbdt_pkg::*;

    localparam int DEPTH = NUM_VERTICES * 8;
    localparam int AW    = $clog2(DEPTH);

    logic [VTX_W-1:0] mem [DEPTH];
    logic [VTX_W-1:0] degree_reg [NUM_VERTICES];
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;

    // A write appends the neighbour at the end of the vertex's list.
    assign waddr = AW'({req.wr_vtx, degree_reg[req.wr_vtx]});
    assign raddr = AW'({req.rd_vtx, req.rd_pos});

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[waddr] <= req.wr_nbr;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[raddr];
        end
    end

    // Degree counts grow by one on every append.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_VERTICES; i++)
            begin
                degree_reg[i] <= '0;
            end
        end
        else if (req.wr_en)
        begin
            degree_reg[req.wr_vtx] <= degree_reg[req.wr_vtx] + VTX_W'(1);
        end
    end

    assign degree = degree_reg;

endmodule

/* src/graph_bfs_dfs_traversal.sv */
// Undirected graph of NUM_VERTICES labelled vertices with breadth-first and
// depth-first walks. An add-edge word matches both labels one vertex at a
// time, reads each existing neighbour of the first vertex for the repeat
// check, and then appends to both lists. A walk word matches the start label
// the same way, then reads adjacency entries from the neighbour memory
// between queue or stack pops, and waits while the output side stalls.
// Results of a walk leave one word per visited vertex, the final one with
// last set; an unknown start label gives one word with status set. The block
// takes no new word until the walk or edge update is done; the last result
// may still wait in the output register while the next word is accepted.
module graph_bfs_dfs_traversal #(
    parameter int NUM_VERTICES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [63:0]                   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    cmd,
    input  logic [gbdt_pkg::LBL_W-1:0]    label_a,
    input  logic [gbdt_pkg::LBL_W-1:0]    label_b,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          status,
    output logic [gbdt_pkg::VTX_W-1:0]    vertex_index,
    output logic [gbdt_pkg::LBL_W-1:0]    vertex_label,
    output logic                          last
);
    import gbdt_pkg::*;

    localparam logic [VTX_W-1:0] LAST_V = VTX_W'(NUM_VERTICES - 1);
    localparam logic [CNT_W-1:0] FULL   = CNT_W'(8);

    state_t            state_reg, state_next;
    logic [63:0]       labels_reg;
    logic [1:0]        cmd_reg, cmd_next;
    logic [LBL_W-1:0]  la_reg, la_next, lb_reg, lb_next;
    logic [VTX_W-1:0]  sc_reg, sc_next;
    logic              fa_reg, fa_next, fb_reg, fb_next;
    logic [VTX_W-1:0]  ia_reg, ia_next, ib_reg, ib_next;
    logic [VTX_W-1:0]  k_reg, k_next;
    logic [VTX_W-1:0]  v_reg, v_next;
    logic [CNT_W-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [NUM_VERTICES-1:0] vis_reg, vis_next;
    logic [VTX_W-1:0]  front_reg [8];
    logic [VTX_W-1:0]  front_next [8];
    logic [VTX_W-1:0]  pos_reg [8];
    logic [VTX_W-1:0]  pos_next [8];
    logic              pend_reg, pend_next;
    logic [VTX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_status_reg, out_status_next;
    logic [VTX_W-1:0]  out_idx_reg, out_idx_next;
    logic [LBL_W-1:0]  out_lbl_reg, out_lbl_next;
    logic              out_last_reg, out_last_next;

    adj_req_t          req;
    logic [VTX_W-1:0]  rd_data;
    logic [VTX_W-1:0]  degree [NUM_VERTICES];
    logic              out_free;
    logic [LBL_W-1:0]  scan_lbl;
    logic [VTX_W-1:0]  top_idx;
    logic [VTX_W-1:0]  top_v, top_p;

    gbdt_adj #(.NUM_VERTICES(NUM_VERTICES)) u_adj (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data),
        .degree  (degree)
    );

    function automatic logic [LBL_W-1:0] label_of(input logic [63:0] lbls,
                                                 input logic [VTX_W-1:0] v);
        return lbls[{v, 3'b000} +: LBL_W];
    endfunction

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign vertex_index = out_idx_reg;
    assign vertex_label = out_lbl_reg;
    assign last         = out_last_reg;
    assign out_free     = !out_valid_reg || out_ready;
    assign scan_lbl     = label_of(labels_reg, sc_reg);
    assign top_idx      = VTX_W'(tail_reg - CNT_W'(1));
    assign top_v        = front_reg[top_idx];
    assign top_p        = pos_reg[top_idx];

    // Sequencer: next state and all register updates but the label table.
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        la_next         = la_reg;
        lb_next         = lb_reg;
        sc_next         = sc_reg;
        fa_next         = fa_reg;
        fb_next         = fb_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        k_next          = k_reg;
        v_next          = v_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        n_next          = n_reg;
        vis_next        = vis_reg;
        front_next      = front_reg;
        pos_next        = pos_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_lbl_next    = out_lbl_reg;
        out_last_next   = out_last_reg;
        req             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && cmd != CMD_RSV)
                begin
                    cmd_next   = cmd;
                    la_next    = label_a;
                    lb_next    = label_b;
                    sc_next    = '0;
                    fa_next    = 1'b0;
                    fb_next    = 1'b0;
                    state_next = S_SCAN;
                    if (cmd != CMD_EDGE)
                    begin
                        vis_next = '0;
                        n_next   = '0;
                    end
                end
            end

            // One vertex label compared per cycle; the first match wins.
            S_SCAN:
            begin
                if (!fa_reg && scan_lbl == la_reg)
                begin
                    fa_next = 1'b1;
                    ia_next = sc_reg;
                end
                if (!fb_reg && scan_lbl == lb_reg)
                begin
                    fb_next = 1'b1;
                    ib_next = sc_reg;
                end
                sc_next = sc_reg + VTX_W'(1);
                if (sc_reg == LAST_V)
                begin
                    k_next = '0;
                    if (cmd_reg == CMD_EDGE)
                    begin
                        if (la_reg == lb_reg || !fa_next || !fb_next)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_LINK;
                        end
                    end
                    else if (!fa_next)
                    begin
                        state_next = S_NF;
                    end
                    else
                    begin
                        pend_next      = 1'b1;
                        pend_idx_next  = ia_next;
                        vis_next[ia_next] = 1'b1;
                        n_next         = CNT_W'(1);
                        front_next[0]  = ia_next;
                        pos_next[0]    = '0;
                        head_next      = '0;
                        tail_next      = CNT_W'(1);
                        state_next     = (cmd_reg == CMD_BFS) ? S_BPOP : S_DTOP;
                    end
                end
            end

            // Walk the first vertex's list looking for the other vertex.
            S_LINK:
            begin
                if (k_reg < degree[ia_reg])
                begin
                    req.rd_en  = 1'b1;
                    req.rd_vtx = ia_reg;
                    req.rd_pos = k_reg;
                    state_next = S_LINKCHK;
                end
                else if (degree[ia_reg] == 3'd7 || degree[ib_reg] == 3'd7)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_WR1;
                end
            end

            S_LINKCHK:
            begin
                k_next     = k_reg + VTX_W'(1);
                state_next = (rd_data == ib_reg) ? S_IDLE : S_LINK;
            end

            S_WR1:
            begin
                req.wr_en  = 1'b1;
                req.wr_vtx = ia_reg;
                req.wr_nbr = ib_reg;
                state_next = S_WR2;
            end

            S_WR2:
            begin
                req.wr_en  = 1'b1;
                req.wr_vtx = ib_reg;
                req.wr_nbr = ia_reg;
                state_next = S_IDLE;
            end

            S_NF:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = 1'b1;
                    out_idx_next    = '0;
                    out_lbl_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            // Breadth-first: pop the queue head.
            S_BPOP:
            begin
                if (head_reg < tail_reg)
                begin
                    v_next     = front_reg[head_reg[VTX_W-1:0]];
                    head_next  = head_reg + CNT_W'(1);
                    k_next     = '0;
                    state_next = S_BNB;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end

            S_BNB:
            begin
                if (k_reg < degree[v_reg])
                begin
                    req.rd_en  = 1'b1;
                    req.rd_vtx = v_reg;
                    req.rd_pos = k_reg;
                    state_next = S_BCHK;
                end
                else
                begin
                    state_next = S_BPOP;
                end
            end

            // A new vertex pushes the held result out and takes its place.
            S_BCHK:
            begin
                if (!vis_reg[rd_data] && tail_reg < FULL && n_reg < FULL)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = 1'b0;
                        out_idx_next    = pend_idx_reg;
                        out_lbl_next    = label_of(labels_reg, pend_idx_reg);
                        out_last_next   = 1'b0;
                        pend_idx_next   = rd_data;
                        vis_next[rd_data] = 1'b1;
                        n_next          = n_reg + CNT_W'(1);
                        front_next[tail_reg[VTX_W-1:0]] = rd_data;
                        tail_next       = tail_reg + CNT_W'(1);
                        k_next          = k_reg + VTX_W'(1);
                        state_next      = S_BNB;
                    end
                end
                else
                begin
                    k_next     = k_reg + VTX_W'(1);
                    state_next = S_BNB;
                end
            end

            // Depth-first: tail counts the stack depth.
            S_DTOP:
            begin
                if (tail_reg == '0)
                begin
                    state_next = S_FLUSH;
                end
                else if (top_p < degree[top_v])
                begin
                    req.rd_en         = 1'b1;
                    req.rd_vtx        = top_v;
                    req.rd_pos        = top_p;
                    pos_next[top_idx] = top_p + VTX_W'(1);
                    state_next        = S_DCHK;
                end
                else
                begin
                    tail_next = tail_reg - CNT_W'(1);
                end
            end

            S_DCHK:
            begin
                if (!vis_reg[rd_data] && tail_reg < FULL && n_reg < FULL)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = 1'b0;
                        out_idx_next    = pend_idx_reg;
                        out_lbl_next    = label_of(labels_reg, pend_idx_reg);
                        out_last_next   = 1'b0;
                        pend_idx_next   = rd_data;
                        vis_next[rd_data] = 1'b1;
                        n_next          = n_reg + CNT_W'(1);
                        front_next[tail_reg[VTX_W-1:0]] = rd_data;
                        pos_next[tail_reg[VTX_W-1:0]]   = '0;
                        tail_next       = tail_reg + CNT_W'(1);
                        state_next      = S_DTOP;
                    end
                end
                else
                begin
                    state_next = S_DTOP;
                end
            end

            // The held result is the final one of the walk.
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = 1'b0;
                    out_idx_next    = pend_idx_reg;
                    out_lbl_next    = label_of(labels_reg, pend_idx_reg);
                    out_last_next   = 1'b1;
                    pend_next       = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            labels_reg    <= '0;
            vis_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            tail_reg      <= '0;
            head_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            vis_reg       <= vis_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            tail_reg      <= tail_next;
            head_reg      <= head_next;
            if (cfg_we)
            begin
                labels_reg <= cfg_wdata;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        la_reg         <= la_next;
        lb_reg         <= lb_next;
        sc_reg         <= sc_next;
        fa_reg         <= fa_next;
        fb_reg         <= fb_next;
        ia_reg         <= ia_next;
        ib_reg         <= ib_next;
        k_reg          <= k_next;
        v_reg          <= v_next;
        front_reg      <= front_next;
        pos_reg        <= pos_next;
        pend_idx_reg   <= pend_idx_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_lbl_reg    <= out_lbl_next;
        out_last_reg   <= out_last_next;
    end

    // No result is held back while the block waits for a new word.
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !pend_reg)
        else $error("held result while idle");

    // Queue tail and stack depth never pass eight entries.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= FULL)
        else $error("frontier overflow");

    // Every visited vertex has been counted as a result.
    a_vis_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BPOP || state_reg == S_BNB || state_reg == S_BCHK ||
         state_reg == S_DTOP || state_reg == S_DCHK)
        |-> ($countones(vis_reg) == 32'(n_reg)))
        else $error("visit flags and result count disagree");

    // A not-found word is always the final word.
    a_nf_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg) |-> out_last_reg)
        else $error("not-found word without last");

endmodule

/* tb/graph_bfs_dfs_traversal_tb.sv */
module graph_bfs_dfs_traversal_tb;

    import gbdt_pkg::*;

    localparam int NV = 8;

    // One command word waiting to be sent.
    typedef struct {
        logic [1:0] cmd;
        logic [7:0] la;
        logic [7:0] lb;
    } cmd_word_t;

    // One visit result as the block reports it.
    typedef struct {
        logic       status;
        logic [2:0] vidx;
        logic [7:0] vlbl;
        logic       last;
    } visit_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [63:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [7:0]  label_a;
    logic [7:0]  label_b;
    logic        out_valid;
    logic        out_ready;
    logic        status;
    logic [2:0]  vertex_index;
    logic [7:0]  vertex_label;
    logic        last;

    cmd_word_t pending_q[$];
    visit_t    visit_q[$];
    int        errors = 0;

    // Graph shadow kept by the predictor.
    logic [63:0] labels_shadow;
    logic [2:0]  adj[NV][8];
    int          degree[NV];
    bit          seen[NV];

    graph_bfs_dfs_traversal #(.NUM_VERTICES(NV)) DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
        .label_a(label_a), .label_b(label_b), .out_valid(out_valid),
        .out_ready(out_ready), .status(status), .vertex_index(vertex_index),
        .vertex_label(vertex_label), .last(last)
    );

    always #5 clk = ~clk;

    // Lowest vertex holding a label, or -1.
    function automatic int find_vtx(logic [7:0] l);
        for (int i = 0; i < NV; i++)
        begin
            if (labels_shadow[i*8 +: 8] == l)
                return i;
        end
        return -1;
    endfunction

    function automatic bit is_linked(int v, int w);
        for (int k = 0; k < degree[v]; k++)
        begin
            if (int'(adj[v][k]) == w)
                return 1;
        end
        return 0;
    endfunction

    // Apply one command word to the shadow graph and queue its visits.
    task automatic walk_graph(cmd_word_t w);
        visit_t res[8];
        int     n;
        int     i;
        int     j;
        int     s;
        int     head;
        int     tail;
        int     sp;
        int     v;
        int     p;
        int     u;
        int     fr[8];
        int     pos[8];
        n = 0;
        if (w.cmd == CMD_EDGE)
        begin
            if (w.la == w.lb)
                return;
            i = find_vtx(w.la);
            j = find_vtx(w.lb);
            if (i < 0 || j < 0 || i == j || is_linked(i, j))
                return;
            if (degree[i] >= 7 || degree[j] >= 7)
                return;
            adj[i][degree[i]] = j[2:0];
            degree[i]++;
            adj[j][degree[j]] = i[2:0];
            degree[j]++;
            return;
        end
        if (w.cmd != CMD_BFS && w.cmd != CMD_DFS)
            return;
        for (int k = 0; k < NV; k++)
            seen[k] = 0;
        s = find_vtx(w.la);
        if (s < 0)
        begin
            visit_q.push_back('{1'b1, 3'd0, 8'd0, 1'b1});
            return;
        end
        res[0] = '{1'b0, s[2:0], labels_shadow[s*8 +: 8], 1'b0};
        seen[s] = 1;
        n = 1;
        if (w.cmd == CMD_BFS)
        begin
            // Breadth-first through a FIFO frontier.
            head = 0;
            tail = 1;
            fr[0] = s;
            while (head < tail)
            begin
                v = fr[head];
                head++;
                for (int k = 0; k < degree[v]; k++)
                begin
                    u = int'(adj[v][k]);
                    if (!seen[u] && tail < 8 && n < 8)
                    begin
                        res[n] = '{1'b0, u[2:0], labels_shadow[u*8 +: 8], 1'b0};
                        seen[u] = 1;
                        n++;
                        fr[tail] = u;
                        tail++;
                    end
                end
            end
        end
        else
        begin
            // Depth-first with an explicit stack of vertex and list position.
            fr[0] = s;
            pos[0] = 0;
            sp = 1;
            while (sp > 0)
            begin
                v = fr[sp-1];
                p = pos[sp-1];
                if (p < degree[v])
                begin
                    u = int'(adj[v][p]);
                    pos[sp-1] = p + 1;
                    if (!seen[u] && sp < 8 && n < 8)
                    begin
                        res[n] = '{1'b0, u[2:0], labels_shadow[u*8 +: 8], 1'b0};
                        seen[u] = 1;
                        n++;
                        fr[sp] = u;
                        pos[sp] = 0;
                        sp++;
                    end
                end
                else
                    sp--;
            end
        end
        res[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            visit_q.push_back(res[k]);
    endtask

    // Driver: bursts of words separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        cmd_word_t nxt;
        if (rst_n && (!in_valid || in_ready))
        begin
            if (in_valid)
                walk_graph('{cmd, label_a, label_b});
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                nxt = pending_q.pop_front();
                in_valid <= 1'b1;
                cmd <= nxt.cmd;
                label_a <= nxt.la;
                label_b <= nxt.lb;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check each visit word, then choose the next ready level.
    int cyc = 0;
    int hold_left = 0;
    int stall_mode = 0;
    always @(posedge clk)
    begin
        visit_t want;
        cyc <= cyc + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (visit_q.size() == 0)
            begin
                $display("%0t: unexpected word status=%0d index=%0d label=%0h last=%0d",
                         $time, status, vertex_index, vertex_label, last);
                errors++;
            end
            else
            begin
                want = visit_q.pop_front();
                if (want.status !== status || want.vidx !== vertex_index ||
                    want.vlbl !== vertex_label || want.last !== last)
                begin
                    $display("%0t: expected status=%0d index=%0d label=%0h last=%0d",
                             $time, want.status, want.vidx, want.vlbl, want.last);
                    $display("%0t: actual   status=%0d index=%0d label=%0h last=%0d",
                             $time, status, vertex_index, vertex_label, last);
                    errors++;
                end
            end
        end
        // One long hold-off early in the run lets the block back up.
        if (cyc == 3000)
            hold_left = 600;
        if (cyc % 500 == 0)
            stall_mode = $urandom_range(0, 2);
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_mode == 0)
            out_ready <= 1'b1;
        else if (stall_mode == 1)
            out_ready <= ($urandom_range(0, 9) < 7);
        else
            out_ready <= ($urandom_range(0, 9) < 2);
    end

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || in_valid || visit_q.size() != 0);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_labels(logic [63:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        labels_shadow = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly edges and walks between known labels, with some noise.
    task automatic add_random(int count);
        cmd_word_t w;
        int        r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            w.la = labels_shadow[$urandom_range(0, NV-1)*8 +: 8];
            w.lb = labels_shadow[$urandom_range(0, NV-1)*8 +: 8];
            if (r < 50)
                w.cmd = CMD_EDGE;
            else if (r < 70)
                w.cmd = CMD_BFS;
            else if (r < 90)
                w.cmd = CMD_DFS;
            else
            begin
                w.cmd = 2'($urandom_range(0, 3));
                w.la = 8'($urandom_range(0, 255));
                w.lb = 8'($urandom_range(0, 255));
            end
            pending_q.push_back(w);
        end
    endtask

    task automatic push_word(logic [1:0] c, logic [7:0] a, logic [7:0] b);
        pending_q.push_back('{c, a, b});
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        cmd = CMD_EDGE;
        label_a = '0;
        label_b = '0;
        out_ready = 1'b0;
        labels_shadow = '0;
        for (int i = 0; i < NV; i++)
            degree[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_labels(64'hFF60_5040_3020_1000);

        // Directed words: extremes, every command and the special cases.
        push_word(CMD_BFS, 8'h00, 8'h00);
        push_word(CMD_EDGE, 8'h00, 8'h10);
        push_word(CMD_EDGE, 8'h00, 8'h20);
        push_word(CMD_EDGE, 8'h10, 8'h30);
        push_word(CMD_EDGE, 8'h20, 8'h30);
        push_word(CMD_EDGE, 8'h10, 8'h00);
        push_word(CMD_EDGE, 8'h40, 8'h40);
        push_word(CMD_EDGE, 8'h77, 8'h40);
        push_word(CMD_EDGE, 8'h40, 8'hAA);
        push_word(CMD_RSV, 8'hFF, 8'hFF);
        push_word(CMD_BFS, 8'h00, 8'hFF);
        push_word(CMD_DFS, 8'h00, 8'h00);
        push_word(CMD_BFS, 8'h55, 8'h00);
        push_word(CMD_DFS, 8'hAA, 8'h00);
        push_word(CMD_DFS, 8'hFF, 8'h00);
        push_word(CMD_EDGE, 8'hFF, 8'h30);
        push_word(CMD_EDGE, 8'h50, 8'h60);
        push_word(CMD_EDGE, 8'h60, 8'hFF);
        push_word(CMD_EDGE, 8'h40, 8'h00);
        push_word(CMD_BFS, 8'h30, 8'h00);
        push_word(CMD_DFS, 8'h60, 8'h00);
        add_random(100);
        wait_drained();

        // Every label equal: only vertex zero can be named.
        write_labels(64'h0);
        add_random(40);
        wait_drained();

        write_labels(64'hFFFF_FFFF_FFFF_FFFF);
        add_random(30);
        wait_drained();

        // Random labels, duplicates likely in the low bits.
        write_labels({$urandom, $urandom});
        add_random(50);
        wait_drained();
        write_labels({$urandom, $urandom} & 64'h0303_0303_0303_0303);
        add_random(40);
        wait_drained();

        // Edges survive a relabel.
        write_labels(64'h0102_0408_1020_4080);
        add_random(80);
        wait_drained();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
